### rtl/pixel_intensity_histogram_unit_defines.svh
// Assertion macros shared by the histogram RTL.
// The module that uses them must have clk_i and rst_ni in scope.
`ifndef PIXEL_INTENSITY_HISTOGRAM_UNIT_DEFINES_SVH
`define PIXEL_INTENSITY_HISTOGRAM_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define PIH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define PIH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pih_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pih_pkg;

  // Field widths.
  localparam int OpW    = 2;
  localparam int BinW   = 8;
  localparam int CountW = 21;

  localparam int NumBins = 2 ** BinW;

  // Largest frame; a bin never counts past it, nor past the field maximum.
  localparam int MaxRows       = 1024;
  localparam int MaxCols       = 1024;
  localparam int FramePixels   = MaxRows * MaxCols;
  localparam int CountFieldMax = (2 ** CountW) - 1;
  localparam logic [CountW-1:0] CountCeiling =
      CountW'((FramePixels < CountFieldMax) ? FramePixels : CountFieldMax);

  // Depth of the command queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [OpW-1:0] {
    OpAdd   = 2'd0,
    OpRead  = 2'd1,
    OpClear = 2'd2
  } pih_op_e;

  typedef enum logic [1:0] {
    CmdAdd,
    CmdRead,
    CmdClear
  } pih_cmd_e;

  typedef enum logic {
    BkIdle,
    BkExec
  } pih_bk_state_e;

  typedef struct packed {
    pih_cmd_e          cmd;
    logic [BinW-1:0]   index;
  } pih_cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic     valid;
    pih_cmd_t data;
  } pih_q_t;

endpackage

`default_nettype wire

### rtl/pih_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one histogram operation.
interface pih_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] pixel_value;

  modport source (output valid, output op, output pixel_value, input ready);
  modport sink   (input valid, input op, input pixel_value, output ready);
endinterface

// Response channel: one bin count.
interface pih_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bin_index;
  logic [20:0] bin_count;

  modport source (output valid, output bin_index, output bin_count, input ready);
  modport sink   (input valid, input bin_index, input bin_count, output ready);
endinterface

`default_nettype wire

### rtl/pih_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pih_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/pih_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pih_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  pih_req_if.sink              req_i,
  output pih_pkg::pih_q_t      q_head_o,
  input  wire logic            q_pop_i
);

  import pih_pkg::*;

  pih_cmd_t           fifo_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;

  pih_cmd_t           cls_cmd;
  logic               cls_keep;
  logic               accept;
  logic               push;
  logic               pop;

  // Classify the request; the unused code is taken and dropped here.
  always_comb begin
    cls_cmd.index = req_i.pixel_value;
    cls_cmd.cmd   = CmdAdd;
    cls_keep      = 1'b1;
    unique case (pih_op_e'(req_i.op))
      OpAdd:   cls_cmd.cmd = CmdAdd;
      OpRead:  cls_cmd.cmd = CmdRead;
      OpClear: cls_cmd.cmd = CmdClear;
      default: cls_keep    = 1'b0;
    endcase
  end

  assign req_i.ready = (cnt_q != QCntW'(QueueDepth));
  assign accept      = req_i.valid && req_i.ready;
  assign push        = accept && cls_keep;
  assign pop         = q_pop_i && (cnt_q != '0);

  assign q_head_o.valid = (cnt_q != '0);
  assign q_head_o.data  = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    cnt_d = cnt_q + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/pih_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_intensity_histogram_unit_defines.svh"

module pih_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  pih_pkg::pih_q_t      q_head_i,
  output logic                 q_pop_o,
  pih_rsp_if.source            rsp_o
);

  import pih_pkg::*;

  pih_bk_state_e        state_q, state_d;
  pih_cmd_t             cur_q, cur_d;
  logic [NumBins-1:0]   bin_vld_q;

  logic                 vld_clr;
  logic                 vld_set;

  logic                 ram_re;
  logic                 ram_we;
  logic [CountW-1:0]    ram_wdata;
  logic [CountW-1:0]    ram_rdata;
  logic [CountW-1:0]    bin_cnt;

  logic                 out_load;
  logic                 out_vld_q, out_vld_d;
  logic [BinW-1:0]      out_idx_q;
  logic [CountW-1:0]    out_cnt_q;

  pih_ram #(
    .Width (CountW),
    .Depth (NumBins)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q.index),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (q_head_i.data.index),
    .rdata_o (ram_rdata)
  );

  // A bin never written since the last clear reads as zero.
  assign bin_cnt   = bin_vld_q[cur_q.index] ? ram_rdata : '0;
  assign ram_wdata = (bin_cnt < CountCeiling) ? bin_cnt + CountW'(1) : bin_cnt;

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    q_pop_o  = 1'b0;
    vld_clr  = 1'b0;
    vld_set  = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (q_head_i.valid) begin
          q_pop_o = 1'b1;
          unique case (q_head_i.data.cmd) inside
            CmdClear: vld_clr = 1'b1;
            CmdAdd, CmdRead: begin
              ram_re  = 1'b1;
              cur_d   = q_head_i.data;
              state_d = BkExec;
            end
            default: ;
          endcase
        end
      end
      BkExec: begin
        unique case (cur_q.cmd)
          CmdAdd: begin
            ram_we  = 1'b1;
            vld_set = 1'b1;
            state_d = BkIdle;
          end
          CmdRead: begin
            if (!out_vld_q || rsp_o.ready) begin
              out_load = 1'b1;
              state_d  = BkIdle;
            end
          end
          default: state_d = BkIdle;
        endcase
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BkIdle;
      out_vld_q <= 1'b0;
      bin_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (vld_clr) begin
        bin_vld_q <= '0;
      end else if (vld_set) begin
        bin_vld_q[cur_q.index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (out_load) begin
      out_idx_q <= cur_q.index;
      out_cnt_q <= bin_cnt;
    end
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.bin_index = out_idx_q;
  assign rsp_o.bin_count = out_cnt_q;

  `PIH_ASSERT_IMP(a_write_only_for_add, ram_we, (state_q == BkExec) && (cur_q.cmd == CmdAdd), "bin memory written outside a pixel add")
  `PIH_ASSERT_IMP(a_count_saturates, ram_we, ram_wdata <= CountCeiling, "bin count written past its ceiling")
  `PIH_ASSERT_NXT(a_clear_empties_bins, vld_clr, bin_vld_q == '0, "bins still marked after a clear")
  `PIH_ASSERT_IMP(a_result_only_for_read, out_load, (state_q == BkExec) && (cur_q.cmd == CmdRead), "result loaded for a request that is not a read")

endmodule

`default_nettype wire

### rtl/pixel_intensity_histogram_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Payload                     Meaning
// req_i     in    op[1:0], pixel_value[7:0]   add a pixel, read a bin, or clear all bins
// rsp_o     out   bin_index[7:0], bin_count   count of the bin named by a read request
//
// The front end takes a request in every cycle while its two-entry command queue has room.
// A pixel add or a bin read holds the back end in Idle and then Exec, for a read-modify-write on
// the bin memory's separate read and write ports; a clear ends in Idle, unused codes never arrive.
// Reset and clear empty all 256 bins at once through per-bin valid flags; there is no sweep.
// A read whose result register is still full waits in the back end, and requests queue up
// behind it until the queue is full, at which point req_i.ready drops.
//
// Architecture: pih_front decodes each request into a command and pushes it into a short
// queue; pih_back pops commands and runs them against the bin memory (pih_ram), keeping a
// valid flag per bin so an unwritten bin reads as zero. Counts saturate at the frame size.

module pixel_intensity_histogram_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pih_req_if.sink    req_i,
  pih_rsp_if.source  rsp_o
);

  import pih_pkg::*;

  // Queue head offered to the back end, and its pop strobe.
  pih_q_t q_head;
  logic   q_pop;

  pih_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_head_o (q_head),
    .q_pop_i  (q_pop)
  );

  pih_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_head_i (q_head),
    .q_pop_o  (q_pop),
    .rsp_o    (rsp_o)
  );

endmodule

`default_nettype wire

### sim/histogram_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the 256 bins and compares
// every response with the oldest bin read still waiting for one.
module histogram_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pih_req_if          req_i,
  pih_rsp_if          rsp_i,
  output int unsigned mismatches_o,
  output int unsigned owed_o,
  output int unsigned checked_o
);

  import pih_pkg::*;

  typedef struct packed {
    logic [BinW-1:0]   index;
    logic [CountW-1:0] count;
  } bin_report_t;

  logic [CountW-1:0] bin_tally [NumBins];
  bin_report_t       owed_reports [$];

  always @(posedge clk_i or negedge rst_ni) begin : track
    bin_report_t     head;
    int unsigned     bad;
    logic [BinW-1:0] idx;
    if (!rst_ni) begin
      for (int i = 0; i < NumBins; i++) bin_tally[i] = '0;
      owed_reports.delete();
      mismatches_o <= 0;
      owed_o       <= 0;
      checked_o    <= 0;
    end else begin
      bad = 0;
      // A response always belongs to a request taken at an earlier edge, so it is
      // matched before this edge's request is added to the list.
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_reports.size() == 0) begin
          $display("%0t: response for bin %0d, count %0d, with no bin read waiting",
                   $time, rsp_i.bin_index, rsp_i.bin_count);
          bad++;
        end else begin
          head = owed_reports.pop_front();
          if (rsp_i.bin_index !== head.index) begin
            $display("%0t: bin index expected %0d, got %0d", $time, head.index,
                     rsp_i.bin_index);
            bad++;
          end
          if (rsp_i.bin_count !== head.count) begin
            $display("%0t: count of bin %0d expected %0d, got %0d", $time, head.index,
                     head.count, rsp_i.bin_count);
            bad++;
          end
          checked_o <= checked_o + 1;
        end
      end
      if (req_i.valid && req_i.ready) begin
        idx = req_i.pixel_value;
        case (req_i.op)
          OpAdd: begin
            if (bin_tally[idx] < CountCeiling) bin_tally[idx] = bin_tally[idx] + 1'b1;
          end
          OpRead: begin
            owed_reports.push_back('{index: idx, count: bin_tally[idx]});
          end
          OpClear: begin
            for (int i = 0; i < NumBins; i++) bin_tally[i] = '0;
          end
          default: ;
        endcase
      end
      mismatches_o <= mismatches_o + bad;
      owed_o       <= owed_reports.size();
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the histogram unit. The checker beside the block does all
// prediction and comparison; this module only makes requests, stalls the response
// side and decides the outcome from the checker's counts.
module tb_top;
  import pih_pkg::*;

  // Code 3 is not part of the operation set; the block must ignore it.
  localparam logic [OpW-1:0]  OpUnused     = 2'd3;
  // The bin that takes a burst of back-to-back pixel adds.
  localparam logic [BinW-1:0] BurstBin     = 8'hC3;
  localparam int unsigned     BurstItems   = 40;
  localparam int unsigned     RandomItems  = 1600;
  localparam int unsigned     SegmentItems = 200;
  // A read passes through the queue and the back end's Idle and Exec states; this is ample.
  localparam int unsigned     DrainCycles  = 16;
  // Even with the longest idles and response stalls on every request, this is several times
  // what the whole run needs.
  localparam int unsigned     LimitCycles  = 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned cycle_count = 0;

  pih_req_if req_if ();
  pih_rsp_if rsp_if ();

  int unsigned mismatches;
  int unsigned owed;
  int unsigned checked;

  // When set, neither side inserts gaps: requests and responses run back to back.
  bit          steady = 1'b0;
  int unsigned adds_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned clears_sent = 0;
  int unsigned unused_sent = 0;
  // A few bins per segment get most of the traffic so their counts climb.
  logic [BinW-1:0] hot_bins [4];

  always #5 clk_i = ~clk_i;

  pixel_intensity_histogram_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  histogram_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .mismatches_o (mismatches),
    .owed_o       (owed),
    .checked_o    (checked)
  );

  // Idle length for either side: none more than half the time, else a random gap, rarely a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Issues one request, after an optional idle gap, and returns at the edge where it is
  // taken. valid stays high when the next request follows with no gap, so it is never
  // lowered and raised within one time step.
  task automatic send_req(input logic [OpW-1:0] op, input logic [BinW-1:0] value);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.pixel_value <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    case (op)
      OpAdd:   adds_sent++;
      OpRead:  reads_sent++;
      OpClear: clears_sent++;
      default: unused_sent++;
    endcase
  endtask

  // Holds off new requests until every bin read has been answered.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
  endtask

  // Response side: ready toggles in random runs so stalls land on every phase of a read.
  initial begin : rsp_stalls
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = idle_gap();
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Hard stop in case the block hangs on either channel.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned     read_pct;
    int unsigned     r;
    logic [BinW-1:0] value;
    req_if.valid       <= 1'b0;
    req_if.op          <= OpAdd;
    req_if.pixel_value <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The lowest and highest bins read as zero straight out of reset.
    send_req(OpRead, 8'h00);
    send_req(OpRead, 8'hFF);
    // Counts on both end bins and on two alternating bit patterns.
    send_req(OpAdd, 8'h00);
    send_req(OpAdd, 8'hFF);
    send_req(OpAdd, 8'hFF);
    send_req(OpAdd, 8'h55);
    send_req(OpAdd, 8'hAA);
    send_req(OpRead, 8'h00);
    send_req(OpRead, 8'hFF);
    send_req(OpRead, 8'h55);
    send_req(OpRead, 8'hAA);
    // The unused code must leave every bin alone and produce no response.
    send_req(OpUnused, 8'hFF);
    send_req(OpUnused, 8'h00);
    send_req(OpRead, 8'hFF);
    // A clear ignores its value and empties every bin, not just the named one.
    send_req(OpClear, 8'hFF);
    send_req(OpRead, 8'hFF);
    send_req(OpRead, 8'h00);
    send_req(OpAdd, 8'h00);
    send_req(OpRead, 8'h00);
    send_req(OpClear, 8'h00);
    send_req(OpRead, 8'h00);

    // Back-to-back adds on one bin with no gaps, so every read-modify-write follows the
    // previous one on the same address. Its neighbor must stay empty, and a clear must
    // bring the bin back to zero.
    steady = 1'b1;
    for (int unsigned k = 0; k < BurstItems; k++) send_req(OpAdd, BurstBin);
    send_req(OpRead, BurstBin);
    send_req(OpRead, BurstBin - 8'd1);
    send_req(OpAdd, BurstBin);
    send_req(OpRead, BurstBin);
    send_req(OpClear, BurstBin);
    send_req(OpRead, BurstBin);
    steady = 1'b0;
    drain();

    // Random part in segments. Two segments run with no idling on either side, two
    // are read-heavy to keep the command queue full behind a stalled response, and
    // one starts only after all responses are in.
    for (int unsigned seg = 0; seg < RandomItems / SegmentItems; seg++) begin
      steady   = (seg == 2 || seg == 5);
      read_pct = (seg == 3 || seg == 6) ? 80 : $urandom_range(15, 45);
      foreach (hot_bins[h]) hot_bins[h] = BinW'($urandom_range(0, 255));
      if (seg == 4) drain();
      for (int unsigned n = 0; n < SegmentItems; n++) begin
        r     = $urandom_range(0, 99);
        value = ($urandom_range(0, 1) != 0) ? hot_bins[$urandom_range(0, 3)]
                                             : BinW'($urandom_range(0, 255));
        if (r == 0) send_req(OpClear, value);
        else if (r < 4) send_req(OpUnused, value);
        else if (r < 4 + read_pct * 96 / 100) send_req(OpRead, value);
        else send_req(OpAdd, value);
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);

    if (owed != 0) $display("%0t: %0d bin reads never got a response", $time, owed);
    $display("summary: %0d requests (%0d pixel adds, %0d bin reads, %0d clears, %0d unused)",
             adds_sent + reads_sent + clears_sent + unused_sent, adds_sent, reads_sent,
             clears_sent, unused_sent);
    $display("summary: %0d bin counts compared, %0d back-to-back adds on bin %0d",
             checked, BurstItems, BurstBin);
    if (mismatches == 0 && owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
